// File: sv/cmcd_pkg.sv
`timescale 1ns / 1ps

package cmcd_pkg;

  localparam int unsigned COLOR_W   = 3;
  localparam int unsigned THRESH_W  = 8;
  localparam int unsigned CMD_W     = 4;
  localparam int unsigned MARKS_W   = 4;
  localparam int unsigned RUN_W     = 8;
  localparam int unsigned LEAD_N    = 3;
  localparam int unsigned PATTERN_N = 11;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [1:0] REG_WHITE     = 2'd0;
  localparam logic [1:0] REG_BLACK     = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic [COLOR_W-1:0]  WHITE_RESET     = 3'd0;
  localparam logic [COLOR_W-1:0]  BLACK_RESET     = 3'd1;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 8'd10;

  localparam logic [CMD_W-1:0] CMD_NONE = 4'd0;

  typedef logic [COLOR_W-1:0] color_t;

  typedef struct packed {
    color_t              white;
    color_t              black;
    logic [THRESH_W-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic               sequence_end;
    logic [MARKS_W-1:0] marks;
  } res_t;

  // first/second/third mark of each pattern; command = pattern index + 1
  localparam color_t PATTERNS [PATTERN_N][LEAD_N] = '{
    '{3'd4, 3'd3, 3'd5}, '{3'd3, 3'd4, 3'd5}, '{3'd3, 3'd4, 3'd3},
    '{3'd5, 3'd4, 3'd3}, '{3'd5, 3'd3, 3'd4}, '{3'd5, 3'd3, 3'd5},
    '{3'd4, 3'd5, 3'd3}, '{3'd5, 3'd4, 3'd5}, '{3'd4, 3'd5, 3'd4},
    '{3'd3, 3'd5, 3'd3}, '{3'd4, 3'd3, 3'd4}
  };

  function automatic logic [CMD_W-1:0] match_command(color_t m0, color_t m1, color_t m2);
    logic [CMD_W-1:0] cmd;
    cmd = CMD_NONE;
    for (int i = PATTERN_N - 1; i >= 0; i--) begin
      if (m0 == PATTERNS[i][0] && m1 == PATTERNS[i][1] && m2 == PATTERNS[i][2]) begin
        cmd = CMD_W'(i + 1);
      end
    end
    return cmd;
  endfunction

endpackage

// File: sv/cmcd_cfg.sv
`timescale 1ns / 1ps

module cmcd_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cmcd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [cmcd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [cmcd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output cmcd_pkg::cfg_t                   cfg_o
);
  import cmcd_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.white     <= WHITE_RESET;
      cfg_q.black     <= BLACK_RESET;
      cfg_q.threshold <= THRESHOLD_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WHITE:     cfg_q.white     <= pwdata[COLOR_W-1:0];
        REG_BLACK:     cfg_q.black     <= pwdata[COLOR_W-1:0];
        REG_THRESHOLD: cfg_q.threshold <= pwdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WHITE:     prdata = APB_DATA_W'(cfg_q.white);
      REG_BLACK:     prdata = APB_DATA_W'(cfg_q.black);
      REG_THRESHOLD: prdata = APB_DATA_W'(cfg_q.threshold);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/cmcd_mark.sv
`timescale 1ns / 1ps

module cmcd_mark #(
  parameter int unsigned SEQUENCE_DEPTH = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  cmcd_pkg::color_t sample_i,
  input  cmcd_pkg::cfg_t   cfg_i,
  output cmcd_pkg::res_t   res_o
);
  import cmcd_pkg::*;

  localparam int unsigned CNT_W = $clog2(SEQUENCE_DEPTH);

  color_t             prev_sample_q;
  logic [RUN_W-1:0]   run_q, run_d;
  color_t             prev_mark_q, prev_mark_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W:0]     count_inc;
  color_t             lead_q [LEAD_N];

  logic same, is_mark, bg_c, bg_pm, add_mark, end_seq, lead_wr;

  always_comb begin
    same      = sample_i == prev_sample_q;
    run_d     = same ? ((run_q == {RUN_W{1'b1}}) ? run_q : run_q + 1'b1) : '0;
    is_mark   = (run_d > cfg_i.threshold) && (sample_i != prev_mark_q);
    bg_c      = (sample_i == cfg_i.white) || (sample_i == cfg_i.black);
    bg_pm     = (prev_mark_q == cfg_i.white) || (prev_mark_q == cfg_i.black);
    add_mark  = is_mark && !bg_c;
    end_seq   = is_mark && bg_c && !bg_pm;
    lead_wr   = add_mark && (count_q < CNT_W'(LEAD_N));
    count_inc = {1'b0, count_q} + 1'b1;

    count_d = count_q;
    if (add_mark) begin
      count_d = (count_inc >= (CNT_W+1)'(SEQUENCE_DEPTH)) ? '0 : count_inc[CNT_W-1:0];
    end
    if (end_seq) begin
      count_d = '0;
    end
    prev_mark_d = is_mark ? sample_i : prev_mark_q;

    res_o.sequence_end = end_seq;
    res_o.marks        = end_seq ? MARKS_W'(count_q) : '0;
    res_o.command      = (end_seq && count_q >= CNT_W'(LEAD_N))
                       ? match_command(lead_q[0], lead_q[1], lead_q[2]) : CMD_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sample_q <= WHITE_RESET;
      run_q         <= '0;
      prev_mark_q   <= WHITE_RESET;
      count_q       <= '0;
    end else if (step_i) begin
      prev_sample_q <= sample_i;
      run_q         <= run_d;
      prev_mark_q   <= prev_mark_d;
      count_q       <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LEAD_N; i++) begin
      if (step_i && lead_wr && count_q == CNT_W'(i)) begin
        lead_q[i] <= sample_i;
      end
    end
  end

endmodule

// File: sv/color_mark_command_decoder_top.sv
`timescale 1ns / 1ps

// Colour mark command decoder. Each input item is one colour sample; every
// item yields exactly one result item after it is accepted (an input
// register, then the mark tracker feeding the result register), and a
// new item is accepted every cycle while the output is not stalled. A
// colour becomes a mark once its run exceeds mark_threshold; marks other
// than white or black are counted, and a white or black mark after a
// coloured one ends the sequence, reporting its mark count and, for three or
// more marks, the command matched from its first three marks (0 when none
// matches). Registers: white_code at 0x0, black_code at 0x4, mark_threshold
// at 0x8; write them only while the block is idle.
module color_mark_command_decoder_top #(
  parameter int unsigned SEQUENCE_DEPTH = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cmcd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cmcd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cmcd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cmcd_pkg::COLOR_W-1:0]      color_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cmcd_pkg::CMD_W-1:0]        command_o,
  output logic                              sequence_end_o,
  output logic [cmcd_pkg::MARKS_W-1:0]      marks_in_sequence_o
);
  import cmcd_pkg::*;

  cfg_t   cfg;
  res_t   res, res_q;
  logic   s1_valid_q, out_valid_q;
  color_t s1_sample_q;
  logic   out_free, s1_move, s1_load;

  cmcd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load || s1_move) begin
      s1_valid_q <= s1_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_sample_q <= color_sample_i;
    end
  end

  cmcd_mark #(
    .SEQUENCE_DEPTH (SEQUENCE_DEPTH)
  ) u_mark (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_move),
    .sample_i (s1_sample_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      res_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign command_o           = res_q.command;
  assign sequence_end_o      = res_q.sequence_end;
  assign marks_in_sequence_o = res_q.marks;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cmcd_pkg::*;

  localparam int unsigned SEQ_DEPTH = 10;

  localparam color_t RED   = 3'd3;
  localparam color_t GREEN = 3'd4;
  localparam color_t BLUE  = 3'd5;

  typedef enum logic [CMD_W-1:0] {
    OP_NONE, OP_VERYSLOW, OP_SLOW, OP_NORMAL, OP_FAST, OP_VERYFAST, OP_PAUSE,
    OP_LEFT, OP_FORWARD, OP_RIGHT, OP_UTURN, OP_GOBACK
  } drive_cmd_e;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0] paddr          = '0;
  logic [APB_DATA_W-1:0] pwdata         = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  color_t                color_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [CMD_W-1:0]      command_o;
  logic                  sequence_end_o;
  logic [MARKS_W-1:0]    marks_in_sequence_o;

  color_t              cfg_white     = WHITE_RESET;
  color_t              cfg_black     = BLACK_RESET;
  logic [THRESH_W-1:0] cfg_threshold = THRESHOLD_RESET;

  color_t             last_sample = WHITE_RESET;
  logic [RUN_W-1:0]   run_len     = '0;
  color_t             last_mark   = WHITE_RESET;
  logic [MARKS_W-1:0] mark_cnt    = '0;
  color_t             first_marks [LEAD_N];

  color_t      pending_samples [$];
  res_t        expected_results [$];
  int unsigned samples_queued  = 0;
  int unsigned mismatch_count  = 0;
  int unsigned results_seen    = 0;
  bit          calm            = 1'b0;

  int unsigned src_gap = 0, src_quiet = 0;
  int unsigned snk_gap = 0, snk_quiet = 0;

  color_mark_command_decoder_top #(
    .SEQUENCE_DEPTH(SEQ_DEPTH)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .color_sample_i     (color_sample_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .command_o          (command_o),
    .sequence_end_o     (sequence_end_o),
    .marks_in_sequence_o(marks_in_sequence_o)
  );

  function automatic drive_cmd_e lookup_command(input color_t a, input color_t b,
                                                input color_t c);
    case ({a, b, c})
      {GREEN, RED, BLUE}:   return OP_VERYSLOW;
      {RED, GREEN, BLUE}:   return OP_SLOW;
      {RED, GREEN, RED}:    return OP_NORMAL;
      {BLUE, GREEN, RED}:   return OP_FAST;
      {BLUE, RED, GREEN}:   return OP_VERYFAST;
      {BLUE, RED, BLUE}:    return OP_PAUSE;
      {GREEN, BLUE, RED}:   return OP_LEFT;
      {BLUE, GREEN, BLUE}:  return OP_FORWARD;
      {GREEN, BLUE, GREEN}: return OP_RIGHT;
      {RED, BLUE, RED}:     return OP_UTURN;
      {GREEN, RED, GREEN}:  return OP_GOBACK;
      default:              return OP_NONE;
    endcase
  endfunction

  function automatic res_t decode_sample(input color_t c);
    res_t r;
    logic c_bg, prev_bg;
    r = '0;
    if (c == last_sample) begin
      if (run_len != '1) run_len = run_len + 1'b1;
    end else begin
      run_len = '0;
    end
    last_sample = c;
    c_bg    = (c == cfg_white) || (c == cfg_black);
    prev_bg = (last_mark == cfg_white) || (last_mark == cfg_black);
    if (run_len > cfg_threshold && c != last_mark) begin
      if (!c_bg) begin
        if (mark_cnt < LEAD_N) first_marks[mark_cnt[1:0]] = c;
        mark_cnt = (mark_cnt + 1 >= SEQ_DEPTH) ? '0 : mark_cnt + 1'b1;
      end
      if (c_bg && !prev_bg) begin
        r.sequence_end = 1'b1;
        r.marks        = mark_cnt;
        if (mark_cnt >= LEAD_N) r.command = lookup_command(first_marks[0], first_marks[1],
                                                           first_marks[2]);
        mark_cnt = '0;
      end
      last_mark = c;
    end
    return r;
  endfunction

  task automatic queue_run(input color_t c, input int unsigned n);
    repeat (n) pending_samples.push_back(c);
    samples_queued += n;
  endtask

  task automatic queue_sequence(input int unsigned thr);
    color_t      palette [3];
    int unsigned idx, last_idx;
    palette  = '{RED, GREEN, BLUE};
    last_idx = 3;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 8))
        queue_run(color_t'($urandom_range(0, 7)), $urandom_range(1, thr + 3));
    end else begin
      queue_run($urandom_range(0, 1) ? cfg_white : cfg_black, thr + 2 + $urandom_range(0, 3));
      repeat ($urandom_range(1, 12)) begin
        idx = $urandom_range(0, 2);
        if (idx == last_idx && $urandom_range(0, 3) != 0) idx = (idx + 1) % 3;
        if ($urandom_range(0, 9) == 0) queue_run(palette[idx], $urandom_range(1, thr + 1));
        else queue_run(palette[idx], thr + 2 + $urandom_range(0, 3));
        last_idx = idx;
      end
      queue_run($urandom_range(0, 1) ? cfg_white : cfg_black, thr + 2 + $urandom_range(0, 3));
    end
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned start;
    start = samples_queued;
    while (samples_queued - start < n) queue_sequence(cfg_threshold);
    wait_idle();
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WHITE:     cfg_white     = val[COLOR_W-1:0];
      REG_BLACK:     cfg_black     = val[COLOR_W-1:0];
      REG_THRESHOLD: cfg_threshold = val[THRESH_W-1:0];
      default:       ;
    endcase
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_gap   <= 0;
      src_quiet <= 0;
    end else if (src_gap != 0) begin
      src_gap <= src_gap - 1;
      if (src_gap == 1 && $urandom_range(0, 3) == 0) src_quiet <= $urandom_range(20, 80);
    end else if (src_quiet != 0) begin
      src_quiet <= src_quiet - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      src_gap <= $urandom_range(1, 18);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snk_gap     <= 0;
      snk_quiet   <= 0;
      out_stall_i <= 1'b0;
    end else if (snk_gap > 1) begin
      snk_gap     <= snk_gap - 1;
      out_stall_i <= 1'b1;
    end else if (snk_gap == 1) begin
      snk_gap     <= 0;
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 3) == 0) snk_quiet <= $urandom_range(20, 80);
    end else if (snk_quiet != 0) begin
      snk_quiet   <= snk_quiet - 1;
      out_stall_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      snk_gap     <= $urandom_range(1, 18);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      color_sample_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_results.push_back(decode_sample(color_sample_i));
      if (!in_valid_i || !in_stall_o) begin
        if (src_gap == 0 && pending_samples.size() != 0) begin
          in_valid_i     <= 1'b1;
          color_sample_i <= pending_samples.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("tb: result %0d unexpected: cmd=%0d end=%0d marks=%0d", results_seen,
                   command_o, sequence_end_o, marks_in_sequence_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (command_o !== want.command || sequence_end_o !== want.sequence_end ||
            marks_in_sequence_o !== want.marks) begin
          if (mismatch_count < 10)
            $display(
              "tb: result %0d expected cmd=%0d end=%0d marks=%0d, got cmd=%0d end=%0d marks=%0d",
              results_seen, want.command, want.sequence_end, want.marks,
              command_o, sequence_end_o, marks_in_sequence_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Two-sample marks: full pattern, short sequence, unmatched four-mark sequence
    write_reg(REG_THRESHOLD, 32'd0);
    queue_run(RED, 2);   queue_run(GREEN, 2); queue_run(BLUE, 2);  queue_run(WHITE_RESET, 2);
    queue_run(RED, 2);   queue_run(BLACK_RESET, 2);
    queue_run(RED, 2);   queue_run(BLUE, 2);  queue_run(GREEN, 2); queue_run(3'd7, 2);
    queue_run(BLACK_RESET, 2);
    wait_idle();

    write_reg(REG_WHITE, 32'd7);
    write_reg(REG_BLACK, 32'd2);
    write_reg(REG_THRESHOLD, 32'd1);
    random_phase(60);

    write_reg(REG_WHITE, 32'd0);
    write_reg(REG_BLACK, 32'd1);
    write_reg(REG_THRESHOLD, 32'd0);
    random_phase(50);

    // red doubles as both white and black
    write_reg(REG_WHITE, 32'd3);
    write_reg(REG_BLACK, 32'd3);
    write_reg(REG_THRESHOLD, 32'd2);
    random_phase(40);

    // threshold of 254, one below the largest, run counter saturates
    write_reg(REG_WHITE, 32'd0);
    write_reg(REG_BLACK, 32'd7);
    write_reg(REG_THRESHOLD, 32'd254);
    queue_run(BLUE, 258);
    queue_run(3'd0, 256);
    wait_idle();

    write_reg(REG_BLACK, 32'd1);
    write_reg(REG_THRESHOLD, 32'd3);
    random_phase(40);
    calm = 1'b1;
    random_phase(40);

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/cmcd_pkg.sv
sv/cmcd_cfg.sv
sv/cmcd_mark.sv
sv/color_mark_command_decoder_top.sv
sim/testbench.sv
